FILE: rtl/assert_macros.svh
// Concurrent assertion helpers for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/jwpf_pkg.sv
`timescale 1ns / 1ps

package jwpf_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned FS_W    = 11;
  localparam int unsigned POS_W   = 11;

  localparam logic [6:0] EV_BUTTON = 7'd1;
  localparam logic [6:0] EV_AXIS   = 7'd2;

  localparam logic [1:0] HDR_MOTOR  = 2'd1;
  localparam logic [1:0] HDR_BUTTON = 2'd2;

  localparam logic [7:0] BTN_A = 8'd0;
  localparam logic [7:0] BTN_X = 8'd3;
  localparam logic [7:0] BTN_Y = 8'd4;

  localparam logic [FS_W-1:0] FS_RESET  = 11'd1000;
  localparam logic [15:0]     SCALE_DEN = 16'd65534;

  typedef logic [7:0][7:0] frame_bytes_t;

endpackage

FILE: rtl/jwpf_in_if.sv
`timescale 1ns / 1ps

interface jwpf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [jwpf_pkg::CODE_W-1:0]            operation;
  logic [jwpf_pkg::CODE_W-1:0]            control_number;
  logic signed [jwpf_pkg::VALUE_W-1:0]    control_value;

  modport source (output valid, operation, control_number, control_value, input ready);
  modport sink (input valid, operation, control_number, control_value, output ready);
endinterface

FILE: rtl/jwpf_out_if.sv
`timescale 1ns / 1ps

interface jwpf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_header;
  logic [7:0] front_left_fwd;
  logic [7:0] front_left_rev;
  logic [7:0] front_right_fwd;
  logic [7:0] front_right_rev;
  logic [7:0] back_left_fwd;
  logic [7:0] back_left_rev;
  logic [7:0] back_right_fwd;
  logic [7:0] back_right_rev;

  modport source (output valid, frame_header, front_left_fwd, front_left_rev,
                  front_right_fwd, front_right_rev, back_left_fwd, back_left_rev,
                  back_right_fwd, back_right_rev, input ready);
  modport sink (input valid, frame_header, front_left_fwd, front_left_rev,
                front_right_fwd, front_right_rev, back_left_fwd, back_left_rev,
                back_right_fwd, back_right_rev, output ready);
endinterface

FILE: rtl/joystick_to_wheel_pwm_frames.sv
// A button transaction goes from acceptance to the emit state, which loads the frame
// register once the output is free; a trigger transaction scales and forms one duty, a
// stick one scales, takes the root and forms two: a bit-serial divider scales and forms
// each wheel duty, a bit-serial root gives the magnitude. One transaction is in work at
// a time; the next is accepted once its frame is loaded or dropped. Synchronous
// active-high reset clears stick positions, button bytes, output valid; fs becomes 1000.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module joystick_to_wheel_pwm_frames (
  input  logic                        clk,
  input  logic                        rst,
  jwpf_in_if.sink                     joy,
  jwpf_out_if.source                  frame,
  input  logic                        cfg_wr_en,
  input  logic [jwpf_pkg::FS_W-1:0]   cfg_wr_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_SQR   = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DLOAD = 3'd5;
  localparam logic [2:0] ST_DUTY  = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]  state;
  logic [jwpf_pkg::FS_W-1:0] fs;
  logic signed [10:0] lx, ly, rx, ry;
  logic [7:0]  btn [8];
  logic        ev_btn;
  logic [2:0]  ev_num;
  logic signed [15:0] ev_value;
  logic [10:0] scal, mag;
  logic [7:0]  duty_m, duty_p;
  logic        duty_idx, dz;
  logic [4:0]  cnt;
  logic [26:0] div_num;
  logic [15:0] div_rem, div_den;
  logic [20:0] sq_val, sq_res, sq_bit;
  logic        out_valid;
  logic [1:0]  out_hdr;
  jwpf_pkg::frame_bytes_t out_bytes;

  // Input decode.
  logic [6:0] in_type;
  logic       accept, pressed;
  logic       axis_start;
  assign in_type = joy.operation[6:0];
  assign accept  = joy.valid && joy.ready;
  assign pressed = (joy.control_value == 16'sd1);
  assign joy.ready = (state == ST_IDLE);
  assign axis_start = accept && in_type == jwpf_pkg::EV_AXIS && joy.control_number < 8'd6;

  // Scaling product.
  logic signed [17:0] base;
  logic [10:0] kmul;
  logic [27:0] prod;
  always_comb begin
    if (ev_num == 3'd1 || ev_num == 3'd3) begin
      base = 18'sd32767 - {{2{ev_value[15]}}, ev_value};
    end else begin
      base = {{2{ev_value[15]}}, ev_value} + 18'sd32767;
    end
    kmul = ev_num[2] ? 11'd1000 : 11'd2000;
    prod = base[16:0] * kmul;
  end

  // Divider step.
  logic [16:0] rem_sh, rem_sub;
  logic        div_ge;
  logic [26:0] div_num_next;
  logic [15:0] div_rem_next;
  always_comb begin
    rem_sh       = {div_rem, div_num[26]};
    rem_sub      = rem_sh - {1'b0, div_den};
    div_ge       = (rem_sh >= {1'b0, div_den});
    div_num_next = {div_num[25:0], div_ge};
    div_rem_next = div_ge ? rem_sub[15:0] : rem_sh[15:0];
  end

  // Square root step.
  logic [21:0] sq_t;
  logic        sq_ge;
  logic [20:0] sq_res_next;
  always_comb begin
    sq_t        = {1'b0, sq_res} + {1'b0, sq_bit};
    sq_ge       = ({1'b0, sq_val} >= sq_t);
    sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  end

  // Selected stick.
  logic signed [10:0] sx, sy;
  logic [10:0] ax, ay;
  logic signed [21:0] xx, yy;
  logic [20:0] sq_sum;
  logic signed [11:0] pdiff;
  logic [10:0] adiff;
  always_comb begin
    sx = ev_num[1] ? rx : lx;
    sy = ev_num[1] ? ry : ly;
    ax = sx[10] ? 11'(-sx) : sx;
    ay = sy[10] ? 11'(-sy) : sy;
    xx = sx * sx;
    yy = sy * sy;
    sq_sum = xx[20:0] + yy[20:0];
    pdiff = $signed({1'b0, ax}) - $signed({1'b0, ay});
    adiff = pdiff[11] ? 11'(-pdiff) : pdiff[10:0];
  end

  // Duty operand.
  logic signed [12:0] dsrc;
  logic [26:0] dp;
  logic [7:0]  duty_res;
  always_comb begin
    if (!duty_idx) begin
      dsrc = ev_num[2] ? $signed({2'b0, scal}) : $signed({2'b0, mag});
    end else if (!ev_num[1]) begin
      dsrc = $signed({2'b0, adiff});
    end else begin
      dsrc = $signed({2'b0, fs}) - $signed({2'b0, ax});
    end
    dp = {15'b0, dsrc[11:0]};
    if (dz) begin
      duty_res = 8'd0;
    end else if (fs == '0 || div_num_next[26:8] != '0) begin
      duty_res = 8'd255;
    end else begin
      duty_res = div_num_next[7:0];
    end
  end

  // Frame assembly.
  logic [1:0] f_hdr;
  jwpf_pkg::frame_bytes_t f_bytes;
  logic drop;
  logic [7:0] m, p;
  always_comb begin
    m = duty_m;
    p = duty_p;
    f_hdr = jwpf_pkg::HDR_MOTOR;
    f_bytes = '0;
    drop = 1'b0;
    if (ev_btn) begin
      f_hdr = jwpf_pkg::HDR_BUTTON;
      f_bytes = {btn[7], btn[6], btn[5], btn[4], btn[3], btn[2], btn[1], btn[0]};
    end else if (ev_num == 3'd4) begin
      f_bytes = {8'd0, m, m, 8'd0, 8'd0, m, m, 8'd0};
    end else if (ev_num == 3'd5) begin
      f_bytes = {m, 8'd0, 8'd0, m, m, 8'd0, 8'd0, m};
    end else if (sx == 0 && sy > 0) begin
      f_bytes = {m, 8'd0, m, 8'd0, m, 8'd0, m, 8'd0};
    end else if (sx == 0 && sy < 0) begin
      f_bytes = {8'd0, m, 8'd0, m, 8'd0, m, 8'd0, m};
    end else if (!ev_num[1]) begin
      if (sx < 0 && sy == 0) begin
        f_bytes = {8'd0, m, m, 8'd0, m, 8'd0, 8'd0, m};
      end else if (sx > 0 && sy == 0) begin
        f_bytes = {m, 8'd0, 8'd0, m, 8'd0, m, m, 8'd0};
      end else if (sx > 0 && sy > 0) begin
        if (ax <= ay) f_bytes = {m, 8'd0, p, 8'd0, p, 8'd0, m, 8'd0};
        else          f_bytes = {m, 8'd0, 8'd0, p, 8'd0, p, m, 8'd0};
      end else if (sx < 0 && sy < 0) begin
        if (ax <= ay) f_bytes = {8'd0, m, 8'd0, p, 8'd0, p, 8'd0, m};
        else          f_bytes = {8'd0, m, p, 8'd0, p, 8'd0, 8'd0, m};
      end else if (sx < 0 && sy > 0) begin
        if (ax <= ay) f_bytes = {p, 8'd0, m, 8'd0, m, 8'd0, p, 8'd0};
        else          f_bytes = {8'd0, p, m, 8'd0, m, 8'd0, 8'd0, p};
      end else if (sx > 0 && sy < 0) begin
        if (ax <= ay) f_bytes = {8'd0, p, 8'd0, m, 8'd0, m, 8'd0, p};
        else          f_bytes = {p, 8'd0, 8'd0, m, 8'd0, m, p, 8'd0};
      end
    end else begin
      if (sx > 0 && sy > 0) begin
        f_bytes = {p, 8'd0, m, 8'd0, p, 8'd0, m, 8'd0};
      end else if (sx < 0 && sy > 0) begin
        f_bytes = {m, 8'd0, p, 8'd0, m, 8'd0, p, 8'd0};
      end else if (sx > 0 && sy < 0) begin
        if (ax <= ay) f_bytes = {8'd0, p, 8'd0, m, 8'd0, p, 8'd0, m};
        else          drop = 1'b1;
      end else if (sx < 0 && sy < 0) begin
        if (ax <= ay) f_bytes = {8'd0, m, 8'd0, p, 8'd0, m, 8'd0, p};
        else          drop = 1'b1;
      end
    end
  end

  logic signed [11:0] pos;
  assign pos = $signed({1'b0, div_num_next[10:0]}) - 12'sd1000;

  logic out_load;
  assign out_load = (state == ST_EMIT) && !drop && (!out_valid || frame.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      fs        <= jwpf_pkg::FS_RESET;
      lx <= '0; ly <= '0; rx <= '0; ry <= '0;
      for (int i = 0; i < 8; i++) btn[i] <= '0;
    end else begin
      if (cfg_wr_en) fs <= cfg_wr_data;
      if (out_load) out_valid <= 1'b1;
      else if (frame.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ev_num   <= joy.control_number[2:0];
            ev_value <= joy.control_value;
            duty_idx <= 1'b0;
            if (in_type == jwpf_pkg::EV_BUTTON) begin
              ev_btn <= 1'b1;
              if (joy.control_number == jwpf_pkg::BTN_A) begin
                btn[0] <= pressed ? 8'd2 : 8'd0;
                state  <= ST_EMIT;
              end else if (joy.control_number == jwpf_pkg::BTN_X) begin
                btn[4] <= pressed ? 8'd5 : 8'd0;
                btn[5] <= pressed ? 8'd6 : 8'd0;
                btn[6] <= pressed ? 8'd7 : 8'd0;
                btn[7] <= pressed ? 8'd8 : 8'd0;
                state  <= ST_EMIT;
              end else if (joy.control_number == jwpf_pkg::BTN_Y) begin
                btn[0] <= pressed ? 8'd1 : 8'd0;
                state  <= ST_EMIT;
              end
            end else if (in_type == jwpf_pkg::EV_AXIS && joy.control_number < 8'd6) begin
              ev_btn <= 1'b0;
              state  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          div_num <= base[17] ? 27'd0 : prod[26:0];
          div_rem <= '0;
          div_den <= jwpf_pkg::SCALE_DEN;
          cnt     <= '0;
          state   <= ST_SCALE;
        end
        ST_SCALE: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd26) begin
            scal <= div_num_next[10:0];
            if (ev_num[2]) begin
              state <= ST_DLOAD;
            end else begin
              unique case (ev_num[1:0])
                2'd0: lx <= pos[10:0];
                2'd1: ly <= pos[10:0];
                2'd2: rx <= pos[10:0];
                2'd3: ry <= pos[10:0];
                default: ;
              endcase
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          sq_val <= sq_sum;
          sq_res <= '0;
          sq_bit <= 21'h100000;
          cnt    <= '0;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_ge) sq_val <= sq_val - sq_t[20:0];
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd10) begin
            mag   <= sq_res_next[10:0];
            state <= ST_DLOAD;
          end
        end
        ST_DLOAD: begin
          dz      <= dsrc[12] || (dsrc == 13'sd0);
          div_num <= (dp << 8) - dp;
          div_rem <= '0;
          div_den <= {5'b0, fs};
          cnt     <= '0;
          state   <= ST_DUTY;
        end
        ST_DUTY: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          cnt     <= cnt + 5'd1;
          if (cnt == 5'd26) begin
            if (!duty_idx) begin
              duty_m <= duty_res;
              if (ev_num[2]) begin
                state <= ST_EMIT;
              end else begin
                duty_idx <= 1'b1;
                state    <= ST_DLOAD;
              end
            end else begin
              duty_p <= duty_res;
              state  <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (drop) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            out_hdr   <= f_hdr;
            out_bytes <= f_bytes;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign frame.valid           = out_valid;
  assign frame.frame_header    = out_hdr;
  assign frame.front_left_fwd  = out_bytes[0];
  assign frame.front_left_rev  = out_bytes[1];
  assign frame.front_right_fwd = out_bytes[2];
  assign frame.front_right_rev = out_bytes[3];
  assign frame.back_left_fwd   = out_bytes[4];
  assign frame.back_left_rev   = out_bytes[5];
  assign frame.back_right_fwd  = out_bytes[6];
  assign frame.back_right_rev  = out_bytes[7];

  `ASSERT_CLK(a_sqrt_bound, (state == ST_SQRT) |-> (cnt <= 5'd10), "sqrt overran")
  `ASSERT_CLK(a_axis_start, axis_start |=> (state == ST_MUL), "axis transaction did not start")
  `ASSERT_CLK_RST(a_reset, rst |=> (state == ST_IDLE && !frame.valid), "reset did not clear control")

endmodule

FILE: verif/jwpf_frame_checker.sv
`timescale 1ns / 1ps

module jwpf_frame_checker (
  input  logic                      clk,
  input  logic                      rst,
  jwpf_in_if                        joy,
  jwpf_out_if                       frame,
  input  logic                      cfg_wr_en,
  input  logic [jwpf_pkg::FS_W-1:0] cfg_wr_data,
  output int                        failures,
  output int                        pending
);

  localparam logic [7:0] AXIS_LEFT_X   = 8'd0;
  localparam logic [7:0] AXIS_LEFT_Y   = 8'd1;
  localparam logic [7:0] AXIS_RIGHT_X  = 8'd2;
  localparam logic [7:0] AXIS_RIGHT_Y  = 8'd3;
  localparam logic [7:0] AXIS_TRIG_L   = 8'd4;
  localparam logic [7:0] AXIS_TRIG_R   = 8'd5;

  typedef struct {
    logic [1:0]             header;
    jwpf_pkg::frame_bytes_t bytes;
  } wheel_frame_t;

  wheel_frame_t expected_frames[$];
  int           full_scale;
  int           lx, ly, rx, ry;
  logic [7:0]   buttons [8];

  string byte_names [8] = '{"front_left_fwd", "front_left_rev", "front_right_fwd",
                            "front_right_rev", "back_left_fwd", "back_left_rev",
                            "back_right_fwd", "back_right_rev"};

  assign pending = expected_frames.size();

  function automatic logic [7:0] wheel_duty(int dividend);
    longint q;
    if (dividend <= 0) return 8'd0;
    if (full_scale == 0) return 8'd255;
    q = longint'(dividend) * 255 / full_scale;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic int stick_root(int unsigned v);
    int unsigned res;
    int unsigned bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return int'(res);
  endfunction

  function automatic wheel_frame_t motor(logic [7:0] b1, b2, b3, b4, b5, b6, b7, b8);
    wheel_frame_t f;
    f.header = jwpf_pkg::HDR_MOTOR;
    f.bytes = {b8, b7, b6, b5, b4, b3, b2, b1};
    return f;
  endfunction

  function automatic wheel_frame_t button_frame();
    wheel_frame_t f;
    f.header = jwpf_pkg::HDR_BUTTON;
    for (int i = 0; i < 8; i++) f.bytes[i] = buttons[i];
    return f;
  endfunction

  function automatic wheel_frame_t left_drive();
    int ax, ay;
    logic [7:0] m, px, py;
    ax = (lx < 0) ? -lx : lx;
    ay = (ly < 0) ? -ly : ly;
    m = wheel_duty(stick_root(lx * lx + ly * ly));
    px = wheel_duty(ax - ay);
    py = wheel_duty(ay - ax);
    if (lx == 0 && ly > 0) return motor(0, m, 0, m, 0, m, 0, m);
    if (lx == 0 && ly < 0) return motor(m, 0, m, 0, m, 0, m, 0);
    if (lx < 0 && ly == 0) return motor(m, 0, 0, m, 0, m, m, 0);
    if (lx > 0 && ly == 0) return motor(0, m, m, 0, m, 0, 0, m);
    if (lx > 0 && ly > 0) begin
      if (ax < ay) return motor(0, m, 0, py, 0, py, 0, m);
      if (ax == ay) return motor(0, m, 0, 0, 0, 0, 0, m);
      return motor(0, m, px, 0, px, 0, 0, m);
    end
    if (lx < 0 && ly < 0) begin
      if (ax < ay) return motor(m, 0, py, 0, py, 0, m, 0);
      if (ax == ay) return motor(m, 0, 0, 0, 0, 0, m, 0);
      return motor(m, 0, 0, px, 0, px, m, 0);
    end
    if (lx < 0 && ly > 0) begin
      if (ax < ay) return motor(0, py, 0, m, 0, m, 0, py);
      if (ax == ay) return motor(0, 0, 0, m, 0, m, 0, 0);
      return motor(px, 0, 0, m, 0, m, px, 0);
    end
    if (lx > 0 && ly < 0) begin
      if (ax < ay) return motor(py, 0, m, 0, m, 0, py, 0);
      if (ax == ay) return motor(0, 0, m, 0, m, 0, 0, 0);
      return motor(0, px, m, 0, m, 0, 0, px);
    end
    return motor(0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  function automatic bit right_drive(output wheel_frame_t f);
    int ax, ay;
    logic [7:0] m, r;
    ax = (rx < 0) ? -rx : rx;
    ay = (ry < 0) ? -ry : ry;
    m = wheel_duty(stick_root(rx * rx + ry * ry));
    r = wheel_duty(full_scale - ax);
    f = motor(0, 0, 0, 0, 0, 0, 0, 0);
    if (rx == 0 && ry > 0) f = motor(0, m, 0, m, 0, m, 0, m);
    else if (rx == 0 && ry < 0) f = motor(m, 0, m, 0, m, 0, m, 0);
    else if (rx > 0 && ry > 0) f = motor(0, m, 0, r, 0, m, 0, r);
    else if (rx < 0 && ry > 0) f = motor(0, r, 0, m, 0, r, 0, m);
    else if (rx > 0 && ry < 0) begin
      if (ax > ay) return 1'b0;
      f = motor(m, 0, r, 0, m, 0, r, 0);
    end else if (rx < 0 && ry < 0) begin
      if (ax > ay) return 1'b0;
      f = motor(r, 0, m, 0, r, 0, m, 0);
    end
    return 1'b1;
  endfunction

  function automatic bit predict_event(logic [7:0] op, logic [7:0] num,
                                       logic signed [15:0] value, output wheel_frame_t f);
    int v;
    bit pressed;
    logic [7:0] t;
    v = int'(value);
    pressed = (v == 1);
    f = motor(0, 0, 0, 0, 0, 0, 0, 0);
    if (op[6:0] == jwpf_pkg::EV_BUTTON) begin
      if (num == jwpf_pkg::BTN_A) begin
        buttons[0] = pressed ? 8'd2 : 8'd0;
      end else if (num == jwpf_pkg::BTN_X) begin
        buttons[4] = pressed ? 8'd5 : 8'd0;
        buttons[5] = pressed ? 8'd6 : 8'd0;
        buttons[6] = pressed ? 8'd7 : 8'd0;
        buttons[7] = pressed ? 8'd8 : 8'd0;
      end else if (num == jwpf_pkg::BTN_Y) begin
        buttons[0] = pressed ? 8'd1 : 8'd0;
      end else begin
        return 1'b0;
      end
      f = button_frame();
      return 1'b1;
    end
    if (op[6:0] != jwpf_pkg::EV_AXIS) return 1'b0;
    case (num)
      AXIS_LEFT_X: begin
        lx = (v + 32767) * 2000 / 65534 - 1000;
        f = left_drive();
      end
      AXIS_LEFT_Y: begin
        ly = (32767 - v) * 2000 / 65534 - 1000;
        f = left_drive();
      end
      AXIS_RIGHT_X: begin
        rx = (v + 32767) * 2000 / 65534 - 1000;
        return right_drive(f);
      end
      AXIS_RIGHT_Y: begin
        ry = (32767 - v) * 2000 / 65534 - 1000;
        return right_drive(f);
      end
      AXIS_TRIG_L: begin
        t = wheel_duty((v + 32767) * 1000 / 65534);
        f = motor(0, t, t, 0, 0, t, t, 0);
      end
      AXIS_TRIG_R: begin
        t = wheel_duty((v + 32767) * 1000 / 65534);
        f = motor(t, 0, 0, t, t, 0, 0, t);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    wheel_frame_t want;
    wheel_frame_t got;
    if (rst) begin
      expected_frames.delete();
      full_scale = int'(jwpf_pkg::FS_RESET);
      lx = 0;
      ly = 0;
      rx = 0;
      ry = 0;
      for (int i = 0; i < 8; i++) buttons[i] = 8'd0;
      failures = 0;
    end else begin
      if (cfg_wr_en) full_scale = int'(cfg_wr_data);
      if (frame.valid && frame.ready) begin
        got.header = frame.frame_header;
        got.bytes = {frame.back_right_rev, frame.back_right_fwd, frame.back_left_rev,
                     frame.back_left_fwd, frame.front_right_rev, frame.front_right_fwd,
                     frame.front_left_rev, frame.front_left_fwd};
        if (expected_frames.size() == 0) begin
          $error("Unexpected frame transaction with header %0d", got.header);
          failures++;
        end else begin
          want = expected_frames.pop_front();
          if (got.header !== want.header) begin
            $error("frame_header: expected %0d, got %0d", want.header, got.header);
            failures++;
          end
          for (int i = 0; i < 8; i++) begin
            if (got.bytes[i] !== want.bytes[i]) begin
              $error("%s: expected %0d, got %0d", byte_names[i], want.bytes[i], got.bytes[i]);
              failures++;
            end
          end
        end
      end
      if (joy.valid && joy.ready) begin
        if (predict_event(joy.operation, joy.control_number, joy.control_value, want))
          expected_frames.push_back(want);
      end
    end
  end

  final begin
    if (expected_frames.size() != 0)
      $error("%0d expected frames never arrived", expected_frames.size());
  end
endmodule

FILE: verif/joystick_to_wheel_pwm_frames_tb.sv
`timescale 1ns / 1ps

module joystick_to_wheel_pwm_frames_tb;

  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_TIME  = 200;
  localparam int HOLD_CYCLES  = 400;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [jwpf_pkg::FS_W-1:0] cfg_wr_data;
  int                        failures;
  int                        pending;
  int                        hold_request;
  bit                        quiet;
  int                        idle_count;

  jwpf_in_if  joy ();
  jwpf_out_if frame ();

  joystick_to_wheel_pwm_frames dut (
    .clk         (clk),
    .rst         (rst),
    .joy         (joy),
    .frame       (frame),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  jwpf_frame_checker frame_checker (
    .clk         (clk),
    .rst         (rst),
    .joy         (joy),
    .frame       (frame),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    int gap;
    frame.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        frame.ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          frame.ready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          frame.ready = 1'b1;
          repeat ($urandom_range(0, 6)) begin
            @(negedge clk);
            if (hold_request > 0) break;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (joy.valid && joy.ready) || (frame.valid && frame.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_event(logic [7:0] op, logic [7:0] num, logic [15:0] value);
    int gap;
    joy.operation = op;
    joy.control_number = num;
    joy.control_value = value;
    joy.valid = 1'b1;
    do @(posedge clk); while (!joy.ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      joy.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    joy.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TIME) @(negedge clk);
  endtask

  task automatic write_full_scale(logic [jwpf_pkg::FS_W-1:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h8001;
    if (r == 3) return 16'(32767 - $urandom_range(0, 40));
    return 16'($urandom);
  endfunction

  task automatic random_event();
    int r;
    logic [7:0] init;
    logic [7:0] buttons [3];
    buttons = '{jwpf_pkg::BTN_A, jwpf_pkg::BTN_X, jwpf_pkg::BTN_Y};
    r = $urandom_range(0, 99);
    init = $urandom_range(0, 3) == 0 ? 8'h80 : 8'h00;
    if (r < 65) begin
      send_event(init | 8'(jwpf_pkg::EV_AXIS), 8'($urandom_range(0, 5)), pick_value());
    end else if (r < 85) begin
      send_event(init | 8'(jwpf_pkg::EV_BUTTON), buttons[$urandom_range(0, 2)],
                 $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)));
    end else begin
      send_event(8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [jwpf_pkg::FS_W-1:0] scales [6];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    joy.valid = 1'b0;
    joy.operation = '0;
    joy.control_number = '0;
    joy.control_value = '0;
    hold_request = 0;
    quiet = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_event(8'(jwpf_pkg::EV_AXIS), 8'd0, 16'h8000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd1, 16'h7FFF);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd0, 16'h0000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd1, 16'h8000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd0, 16'h7FFF);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd1, 16'h0000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd3, 16'h0000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd2, 16'h7FFF);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd3, 16'h4000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd3, 16'hC000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd2, 16'h8001);
    send_event(8'h80 | 8'(jwpf_pkg::EV_AXIS), 8'd4, 16'h7FFF);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd5, 16'h8000);
    send_event(8'(jwpf_pkg::EV_AXIS), 8'd6, 16'h1234);
    send_event(8'(jwpf_pkg::EV_BUTTON), jwpf_pkg::BTN_A, 16'd1);
    send_event(8'(jwpf_pkg::EV_BUTTON), jwpf_pkg::BTN_X, 16'd1);
    send_event(8'h80 | 8'(jwpf_pkg::EV_BUTTON), jwpf_pkg::BTN_Y, 16'd1);
    send_event(8'(jwpf_pkg::EV_BUTTON), jwpf_pkg::BTN_X, 16'd2);
    send_event(8'(jwpf_pkg::EV_BUTTON), jwpf_pkg::BTN_A, 16'hFFFF);
    send_event(8'(jwpf_pkg::EV_BUTTON), 8'd1, 16'd1);
    send_event(8'hFF, 8'hFF, 16'hFFFF);
    send_event(8'd3, 8'd0, 16'd1);

    scales = '{11'd1, 11'd2047, 11'd1000, 11'($urandom_range(1, 2047)),
               11'($urandom_range(300, 1500)), 11'd500};
    for (int phase = 0; phase < 6; phase++) begin
      write_full_scale(scales[phase]);
      quiet = (phase == 2);
      for (int n = 0; n < 320; n++) begin
        if (phase == 3 && n == 100) begin
          hold_request = HOLD_CYCLES;
          quiet = 1'b1;
          repeat (30) random_event();
          quiet = 1'b0;
        end
        if (phase == 4 && n == 160) drain();
        random_event();
      end
    end

    drain();
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
